@@ design/i2c_bit_level_master_macros.svh @@
// Assertion macros shared by the I2C bit-level master RTL.
// Each use expects signals clk and rst_n in the enclosing module.
`ifndef I2C_BIT_LEVEL_MASTER_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_MACROS_SVH

// Check a property on every rising edge outside reset.
`define I2C_BLM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock.
`define I2C_BLM_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/i2c_blm_pkg.sv @@
// Types and codes for the I2C bit-level master.
// Used by every module of the block; depends on nothing.
package i2c_blm_pkg;

    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_START   = 3'd1;
    localparam logic [2:0] REQ_STOP    = 3'd2;
    localparam logic [2:0] REQ_RESTART = 3'd3;
    localparam logic [2:0] REQ_WRITE   = 3'd4;
    localparam logic [2:0] REQ_READ    = 3'd5;

    localparam logic [5:0] WR_ACK_STEP  = 6'd24;
    localparam logic [5:0] WR_BITS_END  = 6'd24;
    localparam logic [5:0] RD_BITS_END  = 6'd16;
    localparam logic [5:0] RD_SCL_LOW   = 6'd16;
    localparam logic [5:0] RD_DRIVE_ACK = 6'd17;
    localparam logic [5:0] RD_SCL_HIGH  = 6'd18;
    localparam logic [1:0] SUB_LAST     = 2'd2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [5:0] {
        CMD_IDLE    = 6'b000001,
        CMD_START   = 6'b000010,
        CMD_STOP    = 6'b000100,
        CMD_RESTART = 6'b001000,
        CMD_WRITE   = 6'b010000,
        CMD_READ    = 6'b100000
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_nack;
        logic       sda_in;
    } req_t;

    typedef struct packed {
        logic       cmd_rejected;
        logic       ack_seen;
        logic [7:0] rx_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl_out;
    } res_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

@@ design/i2c_blm_in_stage.sv @@
// Input register of the I2C bit-level master: unpacks and holds one word.
// Depends on i2c_blm_pkg.
module i2c_blm_in_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2c_blm_pkg::IN_DATA_W-1:0]  s_tdata,  // tx_byte[7:0], send_nack, sda_in, zeros
    input  logic [2:0]                         s_tuser,  // req_type
    output i2c_blm_pkg::hs_t                   in_hs,
    input  logic                               out_ready,
    output i2c_blm_pkg::req_t                  req
);

    logic               valid_reg;
    logic               valid_next;
    i2c_blm_pkg::req_t  req_reg;
    logic               take;

    assign take     = valid_reg && out_ready;
    assign s_tready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.req_type  <= s_tuser;
            req_reg.tx_byte   <= s_tdata[7:0];
            req_reg.send_nack <= s_tdata[8];
            req_reg.sda_in    <= s_tdata[9];
        end
    end

    assign in_hs.valid = valid_reg;
    assign in_hs.ready = take;
    assign req         = req_reg;

endmodule

@@ design/i2c_blm_engine.sv @@
// Phase sequencer of the I2C bit-level master: command state, pin levels
// and the per-word result. Depends on i2c_blm_pkg and the macros header.
`include "i2c_bit_level_master_macros.svh"

module i2c_blm_engine
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_wdata,
    input  logic               fire,
    input  i2c_blm_pkg::req_t  req,
    output i2c_blm_pkg::res_t  res
);

    logic [7:0]         ticks_reg;
    i2c_blm_pkg::cmd_t  cmd_reg, cmd_next;
    logic [5:0]         step_reg, step_next;
    logic [7:0]         delay_reg, delay_next;
    logic [2:0]         bit_reg, bit_next;
    logic [1:0]         sub_reg, sub_next;
    logic [7:0]         shift_reg, shift_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               drv_reg, drv_next;
    logic               nack_reg, nack_next;
    logic               ack_reg, ack_next;
    logic [7:0]         rx_reg, rx_next;
    logic               run;
    logic               last;
    logic               done;
    logic               rejected;
    logic [7:0]         limit;
    logic [7:0]         delay_inc;
    logic               is_cmd;

    assign limit     = (ticks_reg == 8'd0) ? 8'd1 : ticks_reg;
    assign delay_inc = delay_reg + 8'd1;
    assign is_cmd    = (req.req_type == i2c_blm_pkg::REQ_START)
                    || (req.req_type == i2c_blm_pkg::REQ_STOP)
                    || (req.req_type == i2c_blm_pkg::REQ_RESTART)
                    || (req.req_type == i2c_blm_pkg::REQ_WRITE)
                    || (req.req_type == i2c_blm_pkg::REQ_READ);

    always_comb
    begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        delay_next = delay_reg;
        bit_next   = bit_reg;
        sub_next   = sub_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        nack_next  = nack_reg;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        run        = 1'b0;
        last       = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;

        if (is_cmd)
        begin
            if (cmd_reg != i2c_blm_pkg::CMD_IDLE)
            begin
                rejected = 1'b1;
            end
            else
            begin
                step_next  = 6'd0;
                delay_next = 8'd0;
                bit_next   = 3'd0;
                sub_next   = 2'd0;
                run        = 1'b1;
                case (req.req_type)
                    i2c_blm_pkg::REQ_START:   cmd_next = i2c_blm_pkg::CMD_START;
                    i2c_blm_pkg::REQ_STOP:    cmd_next = i2c_blm_pkg::CMD_STOP;
                    i2c_blm_pkg::REQ_RESTART: cmd_next = i2c_blm_pkg::CMD_RESTART;
                    i2c_blm_pkg::REQ_WRITE:
                    begin
                        cmd_next   = i2c_blm_pkg::CMD_WRITE;
                        shift_next = req.tx_byte;
                    end
                    i2c_blm_pkg::REQ_READ:
                    begin
                        cmd_next   = i2c_blm_pkg::CMD_READ;
                        shift_next = 8'd0;
                        nack_next  = req.send_nack;
                    end
                    default:                  cmd_next = i2c_blm_pkg::CMD_IDLE;
                endcase
            end
        end
        else if (cmd_reg != i2c_blm_pkg::CMD_IDLE)
        begin
            if (delay_inc >= limit)
            begin
                delay_next = 8'd0;
                run        = 1'b1;
            end
            else
            begin
                delay_next = delay_inc;
            end
        end

        if (run)
        begin
            case (cmd_next)
                i2c_blm_pkg::CMD_START:
                begin
                    if (step_next == 6'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else if (step_next == 6'd1)
                    begin
                        scl_next = 1'b0;
                    end
                    last = (step_next >= 6'd2);
                end
                i2c_blm_pkg::CMD_STOP:
                begin
                    if (step_next == 6'd1)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else if (step_next == 6'd2)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_next == 6'd3)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    last = (step_next >= 6'd4);
                end
                i2c_blm_pkg::CMD_RESTART:
                begin
                    if (step_next == 6'd1)
                    begin
                        scl_next = 1'b0;
                    end
                    else if (step_next == 6'd2)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    else if (step_next == 6'd3)
                    begin
                        scl_next = 1'b1;
                    end
                    else if (step_next == 6'd4)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else if (step_next == 6'd5)
                    begin
                        scl_next = 1'b0;
                    end
                    last = (step_next >= 6'd6);
                end
                i2c_blm_pkg::CMD_WRITE:
                begin
                    if (step_next < i2c_blm_pkg::WR_BITS_END)
                    begin
                        case (sub_next)
                            2'd0:
                            begin
                                drv_next = 1'b1;
                                sda_next = shift_next[~bit_next];
                            end
                            2'd1:    scl_next = 1'b1;
                            default: scl_next = 1'b0;
                        endcase
                        if (sub_next == i2c_blm_pkg::SUB_LAST)
                        begin
                            sub_next = 2'd0;
                            bit_next = bit_next + 3'd1;
                        end
                        else
                        begin
                            sub_next = sub_next + 2'd1;
                        end
                    end
                    else if (step_next == i2c_blm_pkg::WR_ACK_STEP)
                    begin
                        drv_next = 1'b0;
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        ack_next = req.sda_in;
                        scl_next = 1'b0;
                        drv_next = 1'b1;
                        last     = 1'b1;
                    end
                end
                i2c_blm_pkg::CMD_READ:
                begin
                    if (step_next < i2c_blm_pkg::RD_BITS_END)
                    begin
                        if (!step_next[0])
                        begin
                            scl_next = 1'b0;
                            drv_next = 1'b0;
                        end
                        else
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_next[6:0], req.sda_in};
                        end
                    end
                    else if (step_next == i2c_blm_pkg::RD_SCL_LOW)
                    begin
                        scl_next = 1'b0;
                    end
                    else if (step_next == i2c_blm_pkg::RD_DRIVE_ACK)
                    begin
                        drv_next = 1'b1;
                        sda_next = nack_next;
                    end
                    else if (step_next == i2c_blm_pkg::RD_SCL_HIGH)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        last     = 1'b1;
                    end
                end
                default: last = 1'b1;
            endcase

            if (last)
            begin
                if (cmd_next == i2c_blm_pkg::CMD_READ)
                begin
                    rx_next = shift_next;
                end
                cmd_next   = i2c_blm_pkg::CMD_IDLE;
                step_next  = 6'd0;
                delay_next = 8'd0;
                done       = 1'b1;
            end
            else
            begin
                step_next = step_next + 6'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg   <= i2c_blm_pkg::CMD_IDLE;
            step_reg  <= 6'd0;
            delay_reg <= 8'd0;
            bit_reg   <= 3'd0;
            sub_reg   <= 2'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            nack_reg  <= 1'b0;
            ack_reg   <= 1'b0;
            rx_reg    <= 8'd0;
        end
        else if (fire)
        begin
            cmd_reg   <= cmd_next;
            step_reg  <= step_next;
            delay_reg <= delay_next;
            bit_reg   <= bit_next;
            sub_reg   <= sub_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            nack_reg  <= nack_next;
            ack_reg   <= ack_next;
            rx_reg    <= rx_next;
        end
    end

    assign res.scl_out      = scl_next;
    assign res.sda_out      = sda_next;
    assign res.sda_drive    = drv_next;
    assign res.busy_res     = (cmd_next != i2c_blm_pkg::CMD_IDLE);
    assign res.done_res     = done;
    assign res.rx_data      = rx_next;
    assign res.ack_seen     = ack_next;
    assign res.cmd_rejected = rejected;

    `I2C_BLM_ASSERT(a_cmd_onehot, $onehot(cmd_reg), "command state not one-hot")
    `I2C_BLM_ASSERT(a_idle_clear, (cmd_reg != i2c_blm_pkg::CMD_IDLE) || ((step_reg == 6'd0) && (delay_reg == 8'd0)), "idle with phase count left")
    `I2C_BLM_ASSERT(a_reject_busy, !(fire && rejected) || (cmd_reg != i2c_blm_pkg::CMD_IDLE), "command rejected while idle")
    `I2C_BLM_ASSERT_NEXT(a_done_idle, fire && done, cmd_reg == i2c_blm_pkg::CMD_IDLE, "not idle after completion")

endmodule

@@ design/i2c_blm_out_stage.sv @@
// Result register of the I2C bit-level master: holds and packs one word.
// Depends on i2c_blm_pkg.
module i2c_blm_out_stage
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  i2c_blm_pkg::hs_t                   in_hs,
    output logic                               out_ready,
    input  i2c_blm_pkg::res_t                  res,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2c_blm_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic               valid_reg;
    logic               valid_next;
    i2c_blm_pkg::res_t  res_reg;

    assign out_ready = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_hs.ready)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_hs.valid && out_ready)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(i2c_blm_pkg::OUT_DATA_W - $bits(i2c_blm_pkg::res_t)){1'b0}}, res_reg};

endmodule

@@ design/i2c_bit_level_master.sv @@
// I2C bit-level master. Each input word is one tick or command and yields one
// result word with the pin levels and status after it. One word per clock is
// taken while results drain, set by the single register pass of the phase
// sequencer; a result is registered as its word leaves the in stage, and while a
// result stalls the input register holds one further word before s_tready drops.
// Depends on i2c_blm_pkg and the in stage, engine and out stage modules.
module i2c_bit_level_master
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [7:0]                         cfg_wdata,  // phase_ticks
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [i2c_blm_pkg::IN_DATA_W-1:0]  s_tdata,    // tx_byte[7:0], send_nack, sda_in
    input  logic [2:0]                         s_tuser,    // req_type
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [i2c_blm_pkg::OUT_DATA_W-1:0] m_tdata     // scl_out, sda_out, sda_drive,
                                                           // busy_res, done_res, rx_data[7:0],
                                                           // ack_seen, cmd_rejected
);

    i2c_blm_pkg::hs_t   in_hs;
    i2c_blm_pkg::req_t  req;
    i2c_blm_pkg::res_t  res;
    logic               out_ready;

    i2c_blm_in_stage u_in
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .in_hs     (in_hs),
        .out_ready (out_ready),
        .req       (req)
    );

    i2c_blm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (in_hs.ready),
        .req       (req),
        .res       (res)
    );

    i2c_blm_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_hs     (in_hs),
        .out_ready (out_ready),
        .res       (res),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ tb/sv/tb_i2c_bit_level_master.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the I2C bit-level master: streams tick and command words,
// predicts pin levels and status after every word and checks each result word.
// Depends on i2c_blm_pkg and the i2c_bit_level_master RTL.
module tb_i2c_bit_level_master;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1950;
    localparam logic [2:0] NO_CMD       = i2c_blm_pkg::REQ_TICK;
    localparam logic [2:0] REQ_SPARE_LO = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0] req;
        logic [7:0] txb;
        logic       nack;
        logic       sda;
    } bus_word_t;

    typedef struct {
        logic       scl;
        logic       sda;
        logic       drv;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
        logic       rej;
    } pin_status_t;

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               cfg_we    = 1'b0;
    logic [7:0]                         cfg_wdata = 8'd0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [i2c_blm_pkg::IN_DATA_W-1:0]  s_tdata   = '0;  // tx_byte[7:0], send_nack, sda_in
    logic [2:0]                         s_tuser   = i2c_blm_pkg::REQ_TICK;  // req_type
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [i2c_blm_pkg::OUT_DATA_W-1:0] m_tdata;  // scl, sda, drive, busy, done, rx[7:0],
                                                  // ack_seen, cmd_rejected

    i2c_bit_level_master u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    bus_word_t   word_queue[$];
    pin_status_t status_queue[$];
    bus_word_t   held_word;
    int word_total   = 0;
    int fail_count   = 0;
    int in_gap       = 0;
    int out_wait     = 0;
    bit in_burst     = 1'b0;
    bit out_burst    = 1'b0;
    int quiet_cycles = 0;

    logic [7:0] ticks_per_phase = 8'd1;
    logic [5:0] pin_step   = 6'd0;
    logic [7:0] shreg      = 8'd0;
    logic [2:0] run_cmd    = NO_CMD;
    logic [7:0] tick_count = 8'd0;
    logic       scl_lvl    = 1'b1;
    logic       sda_lvl    = 1'b1;
    logic       sda_drv    = 1'b1;
    logic       nack_req   = 1'b0;
    logic       ack_lvl    = 1'b0;
    logic [7:0] rx_byte    = 8'd0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    task automatic take_phase(input logic sda_bit, output logic done);
        logic [5:0] s;
        logic [2:0] bit_no;
        logic [1:0] sub;
        s = pin_step;
        done = 1'b0;
        case (run_cmd)
            i2c_blm_pkg::REQ_START:
            begin
                if (s == 6'd0)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = 1'b0;
                end
                else if (s == 6'd1)
                    scl_lvl = 1'b0;
                done = (s >= 6'd2);
            end
            i2c_blm_pkg::REQ_STOP:
            begin
                if (s == 6'd1)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = 1'b0;
                end
                else if (s == 6'd2)
                    scl_lvl = 1'b1;
                else if (s == 6'd3)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = 1'b1;
                end
                done = (s >= 6'd4);
            end
            i2c_blm_pkg::REQ_RESTART:
            begin
                if (s == 6'd1)
                    scl_lvl = 1'b0;
                else if (s == 6'd2)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = 1'b1;
                end
                else if (s == 6'd3)
                    scl_lvl = 1'b1;
                else if (s == 6'd4)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = 1'b0;
                end
                else if (s == 6'd5)
                    scl_lvl = 1'b0;
                done = (s >= 6'd6);
            end
            i2c_blm_pkg::REQ_WRITE:
            begin
                if (s < i2c_blm_pkg::WR_BITS_END)
                begin
                    bit_no = 3'(s / 6'd3);
                    sub = 2'(s % 6'd3);
                    if (sub == 2'd0)
                    begin
                        sda_drv = 1'b1;
                        sda_lvl = shreg[3'd7 - bit_no];
                    end
                    else if (sub == i2c_blm_pkg::SUB_LAST)
                        scl_lvl = 1'b0;
                    else
                        scl_lvl = 1'b1;
                end
                else if (s == i2c_blm_pkg::WR_ACK_STEP)
                begin
                    sda_drv = 1'b0;
                    scl_lvl = 1'b1;
                end
                else
                begin
                    ack_lvl = sda_bit;
                    scl_lvl = 1'b0;
                    sda_drv = 1'b1;
                    done = 1'b1;
                end
            end
            i2c_blm_pkg::REQ_READ:
            begin
                if (s < i2c_blm_pkg::RD_BITS_END)
                begin
                    if (!s[0])
                    begin
                        scl_lvl = 1'b0;
                        sda_drv = 1'b0;
                    end
                    else
                    begin
                        scl_lvl = 1'b1;
                        shreg = {shreg[6:0], sda_bit};
                    end
                end
                else if (s == i2c_blm_pkg::RD_SCL_LOW)
                    scl_lvl = 1'b0;
                else if (s == i2c_blm_pkg::RD_DRIVE_ACK)
                begin
                    sda_drv = 1'b1;
                    sda_lvl = nack_req;
                end
                else if (s == i2c_blm_pkg::RD_SCL_HIGH)
                    scl_lvl = 1'b1;
                else
                begin
                    scl_lvl = 1'b0;
                    done = 1'b1;
                end
            end
            default:
                done = 1'b1;
        endcase
        if (done)
        begin
            if (run_cmd == i2c_blm_pkg::REQ_READ)
                rx_byte = shreg;
            run_cmd = NO_CMD;
            pin_step = 6'd0;
            tick_count = 8'd0;
        end
        else
            pin_step = pin_step + 6'd1;
    endtask

    task automatic predict_word(input bus_word_t w);
        pin_status_t r;
        logic done;
        logic rej;
        int limit;
        done = 1'b0;
        rej = 1'b0;
        if (w.req >= i2c_blm_pkg::REQ_START && w.req <= i2c_blm_pkg::REQ_READ)
        begin
            if (run_cmd != NO_CMD)
                rej = 1'b1;
            else
            begin
                run_cmd = w.req;
                pin_step = 6'd0;
                tick_count = 8'd0;
                if (w.req == i2c_blm_pkg::REQ_WRITE)
                    shreg = w.txb;
                else if (w.req == i2c_blm_pkg::REQ_READ)
                begin
                    shreg = 8'd0;
                    nack_req = w.nack;
                end
                take_phase(w.sda, done);
            end
        end
        else if (run_cmd != NO_CMD)
        begin
            limit = (ticks_per_phase == 8'd0) ? 1 : int'(ticks_per_phase);
            if (int'(tick_count) + 1 >= limit)
            begin
                tick_count = 8'd0;
                take_phase(w.sda, done);
            end
            else
                tick_count = tick_count + 8'd1;
        end
        r.scl  = scl_lvl;
        r.sda  = sda_lvl;
        r.drv  = sda_drv;
        r.busy = (run_cmd != NO_CMD);
        r.done = done;
        r.rx   = rx_byte;
        r.ack  = ack_lvl;
        r.rej  = rej;
        status_queue.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_result(input logic [i2c_blm_pkg::OUT_DATA_W-1:0] d);
        pin_status_t e;
        if (status_queue.size() == 0)
        begin
            $display("%0t: result word %0h with none expected, expected none, actual %0h",
                     $time, d, d);
            fail_count++;
        end
        else
        begin
            e = status_queue.pop_front();
            check_field("scl_out", 8'(e.scl), 8'(d[0]));
            check_field("sda_out", 8'(e.sda), 8'(d[1]));
            check_field("sda_drive", 8'(e.drv), 8'(d[2]));
            check_field("busy_res", 8'(e.busy), 8'(d[3]));
            check_field("done_res", 8'(e.done), 8'(d[4]));
            check_field("rx_data", e.rx, d[12:5]);
            check_field("ack_seen", 8'(e.ack), 8'(d[13]));
            check_field("cmd_rejected", 8'(e.rej), 8'(d[14]));
        end
    endtask

    always @(posedge clk)
    begin
        logic next_valid;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_word(held_word);
                next_valid = 1'b0;
            end
            if (!next_valid && word_queue.size() > 0)
            begin
                if (in_gap > 0)
                    in_gap--;
                else
                begin
                    held_word = word_queue.pop_front();
                    s_tuser <= held_word.req;
                    s_tdata <= {6'd0, held_word.sda, held_word.nack, held_word.txb};
                    next_valid = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        in_burst = ~in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 14);
                end
            end
            s_tvalid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                if ($urandom_range(0, 15) == 0)
                    out_burst = ~out_burst;
                out_wait = out_burst ? 0 : $urandom_range(0, 14);
            end
            if (out_wait > 0)
            begin
                out_wait--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_word(input logic [2:0] req, input logic [7:0] txb, input logic nack,
                             input logic sda);
        bus_word_t w;
        w.req = req;
        w.txb = txb;
        w.nack = nack;
        w.sda = sda;
        word_queue.push_back(w);
        word_total++;
    endtask

    task automatic push_tick();
        logic [2:0] req;
        req = i2c_blm_pkg::REQ_TICK;
        if ($urandom_range(0, 9) == 0)
            req = $urandom_range(0, 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        push_word(req, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Tick count is exact, so the command ends on the last tick and the block is idle after.
    task automatic run_command(input logic [2:0] req, input logic [7:0] txb, input logic nack,
                               input int reject_odds);
        int actions;
        int limit;
        int n_ticks;
        case (req)
            i2c_blm_pkg::REQ_START:   actions = 3;
            i2c_blm_pkg::REQ_STOP:    actions = 5;
            i2c_blm_pkg::REQ_RESTART: actions = 7;
            i2c_blm_pkg::REQ_WRITE:   actions = 26;
            default:                  actions = 20;
        endcase
        limit = (ticks_per_phase == 8'd0) ? 1 : int'(ticks_per_phase);
        n_ticks = (actions - 1) * limit;
        push_word(req, txb, nack, 1'($urandom_range(0, 1)));
        for (int i = 0; i < n_ticks; i++)
        begin
            if (reject_odds > 0 && $urandom_range(1, reject_odds) == 1)
                push_word(3'($urandom_range(i2c_blm_pkg::REQ_START, i2c_blm_pkg::REQ_READ)),
                          8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            push_tick();
        end
        repeat ($urandom_range(0, 2)) push_tick();
    endtask

    task automatic run_transaction();
        int n;
        run_command(i2c_blm_pkg::REQ_START, 8'd0, 1'b0, 20);
        n = $urandom_range(1, 3);
        repeat (n) run_command(i2c_blm_pkg::REQ_WRITE, 8'($urandom), 1'b0, 20);
        if ($urandom_range(0, 1))
        begin
            run_command(i2c_blm_pkg::REQ_RESTART, 8'd0, 1'b0, 20);
            run_command(i2c_blm_pkg::REQ_WRITE, 8'($urandom), 1'b0, 20);
            n = $urandom_range(1, 2);
            for (int i = 0; i < n; i++)
                run_command(i2c_blm_pkg::REQ_READ, 8'($urandom),
                            (i == n - 1) ? 1'b1 : 1'($urandom_range(0, 1)), 20);
        end
        run_command(i2c_blm_pkg::REQ_STOP, 8'd0, 1'b0, 20);
    endtask

    task automatic run_noise();
        repeat ($urandom_range(0, 3)) push_tick();
        run_command(3'($urandom_range(i2c_blm_pkg::REQ_START, i2c_blm_pkg::REQ_READ)),
                    8'($urandom), 1'($urandom_range(0, 1)), 4);
    endtask

    task automatic wait_idle();
        forever
        begin
            @(negedge clk);
            if (word_queue.size() == 0 && !s_tvalid && status_queue.size() == 0)
            begin
                if (run_cmd == NO_CMD)
                    break;
                push_tick();
            end
        end
    endtask

    task automatic write_config(input logic [7:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        ticks_per_phase = value;
    endtask

    task automatic run_phase(input logic [7:0] value, input int n_tx);
        write_config(value);
        repeat (n_tx)
        begin
            if ($urandom_range(0, 4) == 0)
                run_noise();
            else
                run_transaction();
        end
    endtask

    initial
    begin
        logic [7:0] pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks and spare codes, then each command at the reset phase length
        push_word(i2c_blm_pkg::REQ_TICK, 8'hFF, 1'b1, 1'b1);
        push_word(REQ_SPARE_LO, 8'h00, 1'b0, 1'b0);
        push_word(REQ_SPARE_HI, 8'hFF, 1'b1, 1'b1);
        run_command(i2c_blm_pkg::REQ_STOP, 8'h00, 1'b0, 0);
        run_command(i2c_blm_pkg::REQ_START, 8'h00, 1'b0, 0);
        run_command(i2c_blm_pkg::REQ_WRITE, 8'hFF, 1'b0, 1);
        run_command(i2c_blm_pkg::REQ_WRITE, 8'h00, 1'b1, 0);
        run_command(i2c_blm_pkg::REQ_RESTART, 8'h00, 1'b0, 0);
        run_command(i2c_blm_pkg::REQ_READ, 8'h00, 1'b1, 0);
        run_command(i2c_blm_pkg::REQ_READ, 8'hFF, 1'b0, 0);
        run_command(i2c_blm_pkg::REQ_STOP, 8'h00, 1'b0, 0);

        run_phase(8'd1, 2);
        run_phase(8'd0, 1);
        write_config(8'd255);
        run_command(i2c_blm_pkg::REQ_START, 8'($urandom), 1'b0, 50);
        while (word_total < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 3))
                0:       pick = 8'd1;
                1:       pick = 8'd2;
                2:       pick = 8'd3;
                default: pick = 8'($urandom_range(1, 8));
            endcase
            run_phase(pick, 1);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && status_queue.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
